>>> sv/hccf_pkg.sv
`timescale 1ns / 1ps
package hccf_pkg;

  localparam int MAX_HITS     = 64;
  localparam int MAX_ELEMENTS = 256;
  localparam int RESULT_CAP   = 64;

  localparam int HIDX_W = $clog2(MAX_HITS);
  localparam int FILL_W = HIDX_W + 1;
  localparam int ELEM_W = 8;
  localparam int ADC_W  = 16;
  localparam int TDC_W  = 16;
  localparam int SUM_W  = 22;
  localparam int CNT_W  = 7;
  localparam int REP_W  = 6;
  localparam int GRP_W  = $clog2(RESULT_CAP);
  localparam int EA_W   = SUM_W + ELEM_W;
  localparam int DIV_W  = EA_W + 2;
  localparam int KCNT_W = $clog2(ELEM_W);
  localparam int HIT_W  = ELEM_W + ADC_W + TDC_W;

  localparam int ECNT_W    = 9;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 9;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [ECNT_W-1:0] ECNT_RESET = ECNT_W'(MAX_ELEMENTS);

  localparam logic [CFG_IDX_W-1:0] CFG_WRAP_ENABLE   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_COUNT = CFG_IDX_W'(1);

  typedef struct packed {
    logic              wrap_enable;
    logic [ECNT_W-1:0] element_count;
  } cfg_t;

  typedef struct packed {
    logic              usable;
    logic              event_end;
    logic [ELEM_W-1:0] element;
    logic [ADC_W-1:0]  adc;
    logic [TDC_W-1:0]  tdc;
  } cmd_t;

  function automatic logic neighbours(input logic [ELEM_W-1:0] a,
                                      input logic [ELEM_W-1:0] b,
                                      input cfg_t c);
    logic [ELEM_W-1:0] d;
    d = (a > b) ? a - b : b - a;
    return (d <= ELEM_W'(1)) ||
           (c.wrap_enable && (c.element_count != '0) &&
            ({1'b0, d} == c.element_count - ECNT_W'(1)));
  endfunction

endpackage

>>> sv/hit_cluster_centroid_finder.sv
`timescale 1ns / 1ps
// channel  | handshake            | words
// ---------+----------------------+-------------------------------------------
// cfg      | cfg_valid/cfg_ready  | cfg_index, cfg_data (0 wrap, 1 count)
// in       | in_valid/in_ready    | element, adc, tdc, usable, event_end
// out      | out_valid/out_ready  | centroid, adc_sum, cluster_tdc, hit_count,
//          |                      | rep_index, none_found, overflow, cluster_last
//
// a hit word is loaded into the hit ram through a four-deep queue
// at event end the cluster search walks the hit ram through its single read port
// each cluster's centroid is found by restoring division with an eight-bit quotient
// reset (rst, synchronous) empties the queue and the hit store, wrap off,
// element count 256; cfg_ready is always high
// the front keeps taking hit words while a result waits on out_ready, until its queue is full
module hit_cluster_centroid_finder (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [hccf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hccf_pkg::CFG_DAT_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [hccf_pkg::ELEM_W-1:0]    element,
  input  logic [hccf_pkg::ADC_W-1:0]     adc,
  input  logic [hccf_pkg::TDC_W-1:0]     tdc,
  input  logic                           usable,
  input  logic                           event_end,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [hccf_pkg::ELEM_W-1:0]    centroid,
  output logic [hccf_pkg::SUM_W-1:0]     adc_sum,
  output logic [hccf_pkg::TDC_W-1:0]     cluster_tdc,
  output logic [hccf_pkg::CNT_W-1:0]     hit_count,
  output logic [hccf_pkg::REP_W-1:0]     rep_index,
  output logic                           none_found,
  output logic                           overflow,
  output logic                           cluster_last
);
  import hccf_pkg::*;

  cfg_t cfg;
  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;

  // configuration registers; the user writes them only while idle, the block does not enforce it
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wrap_enable   <= 1'b0;
      cfg.element_count <= ECNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_WRAP_ENABLE:   cfg.wrap_enable   <= cfg_data[0];
        CFG_ELEMENT_COUNT: cfg.element_count <= ECNT_W'(cfg_data);
        default: begin
          // unknown register, write ignored
        end
      endcase
    end
  end

  // front: drops no-op words and queues store / close commands
  hccf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .element   (element),
    .adc       (adc),
    .tdc       (tdc),
    .usable    (usable),
    .event_end (event_end),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop)
  );

  // back: hit store, connected-component walk, centroid and result register
  hccf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_valid      (q_valid),
    .q_cmd        (q_cmd),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .centroid     (centroid),
    .adc_sum      (adc_sum),
    .cluster_tdc  (cluster_tdc),
    .hit_count    (hit_count),
    .rep_index    (rep_index),
    .none_found   (none_found),
    .overflow     (overflow),
    .cluster_last (cluster_last)
  );

endmodule

>>> sv/hccf_ram.sv
`timescale 1ns / 1ps
module hccf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/hccf_front.sv
`timescale 1ns / 1ps
module hccf_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [hccf_pkg::ELEM_W-1:0] element,
  input  logic [hccf_pkg::ADC_W-1:0]  adc,
  input  logic [hccf_pkg::TDC_W-1:0]  tdc,
  input  logic                       usable,
  input  logic                       event_end,
  output logic                       q_valid,
  output hccf_pkg::cmd_t             q_cmd,
  input  logic                       q_pop
);
  import hccf_pkg::*;

  cmd_t              q_mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              push;

  assign in_ready = (count != (QPTR_W + 1)'(QDEPTH));
  // words that neither store a hit nor close an event are dropped here
  assign push    = in_valid && in_ready && (usable || event_end);
  assign q_valid = (count != '0);
  assign q_cmd   = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !q_pop) begin
        count <= count + (QPTR_W + 1)'(1);
      end else if (!push && q_pop) begin
        count <= count - (QPTR_W + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= '{usable: usable, event_end: event_end,
                         element: element, adc: adc, tdc: tdc};
    end
  end

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (count != '0))
    else $error("queue popped while empty");

endmodule

>>> sv/hccf_back.sv
`timescale 1ns / 1ps
module hccf_back (
  input  logic                         clk,
  input  logic                         rst,
  input  hccf_pkg::cfg_t               cfg,
  input  logic                         q_valid,
  input  hccf_pkg::cmd_t               q_cmd,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [hccf_pkg::ELEM_W-1:0]  centroid,
  output logic [hccf_pkg::SUM_W-1:0]   adc_sum,
  output logic [hccf_pkg::TDC_W-1:0]   cluster_tdc,
  output logic [hccf_pkg::CNT_W-1:0]   hit_count,
  output logic [hccf_pkg::REP_W-1:0]   rep_index,
  output logic                         none_found,
  output logic                         overflow,
  output logic                         cluster_last
);
  import hccf_pkg::*;

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b000_0000_0001,
    ST_SCAN  = 11'b000_0000_0010,
    ST_ROOT  = 11'b000_0000_0100,
    ST_PICK  = 11'b000_0000_1000,
    ST_CUR   = 11'b000_0001_0000,
    ST_SWEEP = 11'b000_0010_0000,
    ST_DIV   = 11'b000_0100_0000,
    ST_REP   = 11'b000_1000_0000,
    ST_TDC   = 11'b001_0000_0000,
    ST_TDW   = 11'b010_0000_0000,
    ST_OUT   = 11'b100_0000_0000
  } state_t;

  state_t              state;
  logic [FILL_W-1:0]   fill;
  logic                dropped;
  logic [MAX_HITS-1:0] seen;
  logic [MAX_HITS-1:0] pending;
  logic [MAX_HITS-1:0] member;
  logic [FILL_W-1:0]   i;
  logic [FILL_W-1:0]   j;
  logic [HIDX_W-1:0]   j_d;
  logic                v_d;
  logic [HIDX_W-1:0]   cur;
  logic [ELEM_W-1:0]   cur_e;
  logic [SUM_W-1:0]    sum_a;
  logic [EA_W-1:0]     sum_ea;
  logic [CNT_W-1:0]    cnt;
  logic [HIDX_W-1:0]   first_i;
  logic [ELEM_W-1:0]   first_e;
  logic [DIV_W-1:0]    rem;
  logic [SUM_W:0]      den;
  logic [ELEM_W-1:0]   quo;
  logic [KCNT_W-1:0]   k;
  logic [HIDX_W-1:0]   rep;
  logic [TDC_W-1:0]    res_tdc;
  logic [GRP_W-1:0]    grp;
  logic                last_r;
  logic                none_r;

  logic                    we;
  logic [HIDX_W-1:0]       raddr;
  logic [HIT_W-1:0]        rdata;
  logic [ELEM_W-1:0]       r_e;
  logic [ADC_W-1:0]        r_a;
  logic [TDC_W-1:0]        r_t;
  logic [ELEM_W+ADC_W-1:0] prod;
  logic [MAX_HITS-1:0]     fill_mask;
  logic                    more;
  logic                    nb;
  logic                    store_ok;
  logic [FILL_W-1:0]       fill_after;
  logic [DIV_W-1:0]        trial;
  logic                    sweep_on;

  assign {r_e, r_a, r_t} = rdata;
  assign prod     = r_e * r_a;
  assign nb       = neighbours(cur_e, r_e, cfg);
  assign store_ok = (fill < FILL_W'(MAX_HITS));
  assign fill_after = fill + FILL_W'(q_cmd.usable && store_ok);
  assign trial    = DIV_W'(den) << k;
  assign sweep_on = ((state == ST_SWEEP) || (state == ST_REP)) && (j < fill);
  assign q_pop    = (state == ST_IDLE) && q_valid;
  assign we       = q_pop && q_cmd.usable && store_ok;

  always_comb begin
    for (int n = 0; n < MAX_HITS; n++) begin
      fill_mask[n] = (FILL_W'(n) < fill);
    end
  end
  assign more = |(~seen & fill_mask);

  always_comb begin
    unique case (state)
      ST_SCAN:           raddr = i[HIDX_W-1:0];
      ST_PICK:           raddr = cur;
      ST_SWEEP, ST_REP:  raddr = j[HIDX_W-1:0];
      ST_TDC:            raddr = rep;
      default:           raddr = '0;
    endcase
  end

  hccf_ram #(.WIDTH(HIT_W), .DEPTH(MAX_HITS)) u_hits (
    .clk   (clk),
    .we    (we),
    .waddr (fill[HIDX_W-1:0]),
    .wdata ({q_cmd.element, q_cmd.adc, q_cmd.tdc}),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      fill    <= '0;
      dropped <= 1'b0;
      seen    <= '0;
      pending <= '0;
      member  <= '0;
      v_d     <= 1'b0;
      grp     <= '0;
    end else begin
      v_d <= sweep_on;
      j_d <= j[HIDX_W-1:0];
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            if (q_cmd.usable) begin
              if (store_ok) begin
                fill <= fill + FILL_W'(1);
              end else begin
                dropped <= 1'b1;
              end
            end
            if (q_cmd.event_end) begin
              grp <= '0;
              i   <= '0;
              if (fill_after == '0) begin
                none_r  <= 1'b1;
                last_r  <= 1'b1;
                quo     <= '0;
                sum_a   <= '0;
                cnt     <= '0;
                rep     <= '0;
                res_tdc <= '0;
                state   <= ST_OUT;
              end else begin
                none_r <= 1'b0;
                state  <= ST_SCAN;
              end
            end
          end
        end
        ST_SCAN: begin
          if (i >= fill) begin
            fill    <= '0;
            dropped <= 1'b0;
            seen    <= '0;
            pending <= '0;
            state   <= ST_IDLE;
          end else if (!seen[i[HIDX_W-1:0]]) begin
            state <= ST_ROOT;
          end else begin
            i <= i + FILL_W'(1);
          end
        end
        ST_ROOT: begin
          seen[i[HIDX_W-1:0]]    <= 1'b1;
          pending[i[HIDX_W-1:0]] <= 1'b1;
          member[i[HIDX_W-1:0]]  <= 1'b1;
          sum_a   <= SUM_W'(r_a);
          sum_ea  <= EA_W'(prod);
          cnt     <= CNT_W'(1);
          first_i <= i[HIDX_W-1:0];
          first_e <= r_e;
          cur     <= i[HIDX_W-1:0];
          state   <= ST_PICK;
        end
        ST_PICK: begin
          if (pending == '0) begin
            last_r <= !more || (grp == GRP_W'(RESULT_CAP - 1));
            if (sum_a == '0) begin
              quo   <= first_e;
              rep   <= first_i;
              state <= ST_TDC;
            end else begin
              rem   <= DIV_W'({sum_ea, 1'b0}) + DIV_W'(sum_a);
              den   <= {sum_a, 1'b0};
              quo   <= '0;
              k     <= KCNT_W'(ELEM_W - 1);
              state <= ST_DIV;
            end
          end else if (pending[cur]) begin
            state <= ST_CUR;
          end else begin
            cur <= (FILL_W'(cur) + FILL_W'(1) == fill) ? '0 : cur + HIDX_W'(1);
          end
        end
        ST_CUR: begin
          cur_e        <= r_e;
          pending[cur] <= 1'b0;
          j            <= '0;
          state        <= ST_SWEEP;
        end
        ST_SWEEP: begin
          if (j < fill) begin
            j <= j + FILL_W'(1);
          end
          if (v_d && !seen[j_d] && nb) begin
            seen[j_d]    <= 1'b1;
            pending[j_d] <= 1'b1;
            member[j_d]  <= 1'b1;
            sum_a        <= sum_a + SUM_W'(r_a);
            sum_ea       <= sum_ea + EA_W'(prod);
            cnt          <= cnt + CNT_W'(1);
          end
          if ((j == fill) && !v_d) begin
            state <= ST_PICK;
          end
        end
        ST_DIV: begin
          // restoring division, one quotient bit per cycle
          if (rem >= trial) begin
            rem    <= rem - trial;
            quo[k] <= 1'b1;
          end
          if (k == '0) begin
            rep   <= first_i;
            j     <= '0;
            state <= ST_REP;
          end else begin
            k <= k - KCNT_W'(1);
          end
        end
        ST_REP: begin
          if (j < fill) begin
            j <= j + FILL_W'(1);
          end
          if (v_d && member[j_d] && (r_e == quo)) begin
            rep <= j_d;
          end
          if ((j == fill) && !v_d) begin
            state <= ST_TDC;
          end
        end
        ST_TDC: begin
          state <= ST_TDW;
        end
        ST_TDW: begin
          res_tdc <= r_t;
          state   <= ST_OUT;
        end
        ST_OUT: begin
          if (out_ready) begin
            member <= '0;
            grp    <= grp + GRP_W'(1);
            if (last_r) begin
              fill    <= '0;
              dropped <= 1'b0;
              seen    <= '0;
              pending <= '0;
              state   <= ST_IDLE;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid    = (state == ST_OUT);
  assign centroid     = quo;
  assign adc_sum      = sum_a;
  assign cluster_tdc  = res_tdc;
  assign hit_count    = cnt;
  assign rep_index    = REP_W'(rep);
  assign none_found   = none_r;
  assign overflow     = dropped;
  assign cluster_last = last_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(MAX_HITS))
    else $error("hit store fill beyond capacity");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && cluster_last) |=> ((fill == '0) && (state == ST_IDLE)))
    else $error("event not closed after final word");

  a_none_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && none_found) |-> (cluster_last && (hit_count == '0)))
    else $error("empty-event word malformed");

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
module tb;
  import hccf_pkg::*;

  // one expected or observed cluster word
  typedef struct {
    logic [ELEM_W-1:0] centroid;
    logic [SUM_W-1:0]  adc_sum;
    logic [TDC_W-1:0]  cluster_tdc;
    logic [CNT_W-1:0]  hit_count;
    logic [REP_W-1:0]  rep_index;
    logic              none_found;
    logic              overflow;
    logic              cluster_last;
  } cluster_t;

  // keeps its own copy of the hit store and the config, and a queue of
  // the cluster words each event_end word must produce
  class centroid_scoreboard;
    logic [ELEM_W-1:0] elem_mem [MAX_HITS];
    logic [ADC_W-1:0]  adc_mem  [MAX_HITS];
    logic [TDC_W-1:0]  tdc_mem  [MAX_HITS];
    int                fill;
    bit                dropped;
    bit                wrap_on;
    int                ecount;
    cluster_t          clusters_due [$];
    int                errors;
    int                checked;
    int                events;

    function new();
      fill = 0;
      dropped = 0;
      wrap_on = 0;
      ecount = MAX_ELEMENTS;
      errors = 0;
      checked = 0;
      events = 0;
    endfunction

    function bit adjacent(int a, int b);
      int d;
      d = (a > b) ? a - b : b - a;
      return (d <= 1) || (wrap_on && ecount >= 1 && d == ecount - 1);
    endfunction

    // called for every accepted hit word
    function void note_hit(logic [ELEM_W-1:0] e, logic [ADC_W-1:0] a,
                           logic [TDC_W-1:0] t, logic use_it, logic last);
      int       grp [MAX_HITS];
      bit       seen [MAX_HITS];
      int       work [$];
      int       groups, cur, first, rep, cnt, cent, emit;
      longint   sa, sea;
      bit       have_first;
      cluster_t r;
      if (use_it) begin
        if (fill < MAX_HITS) begin
          elem_mem[fill] = e;
          adc_mem[fill] = a;
          tdc_mem[fill] = t;
          fill++;
        end else begin
          dropped = 1;
        end
      end
      if (!last) return;
      events++;
      // connected components, breadth first from the earliest unlabeled hit
      groups = 0;
      for (int i = 0; i < fill; i++) seen[i] = 0;
      for (int i = 0; i < fill; i++) begin
        if (seen[i]) continue;
        seen[i] = 1;
        grp[i] = groups;
        work.delete();
        work.push_back(i);
        while (work.size() > 0) begin
          cur = work.pop_front();
          for (int j = 0; j < fill; j++) begin
            if (!seen[j] && adjacent(elem_mem[cur], elem_mem[j])) begin
              seen[j] = 1;
              grp[j] = groups;
              work.push_back(j);
            end
          end
        end
        groups++;
      end
      if (groups == 0) begin
        r = '{default: '0};
        r.none_found = 1;
        r.overflow = dropped;
        r.cluster_last = 1;
        clusters_due.push_back(r);
      end else begin
        emit = (groups > RESULT_CAP) ? RESULT_CAP : groups;
        for (int c = 0; c < emit; c++) begin
          sa = 0;
          sea = 0;
          cnt = 0;
          first = 0;
          have_first = 0;
          for (int i = 0; i < fill; i++) begin
            if (grp[i] != c) continue;
            if (!have_first) begin
              first = i;
              have_first = 1;
            end
            cnt++;
            sa += adc_mem[i];
            sea += longint'(elem_mem[i]) * adc_mem[i];
          end
          rep = first;
          if (sa != 0) begin
            cent = int'((2 * sea + sa) / (2 * sa));
            // last hit sitting on the centroid element wins
            for (int i = 0; i < fill; i++)
              if (grp[i] == c && elem_mem[i] == cent) rep = i;
          end else begin
            cent = elem_mem[first];
          end
          r.centroid = cent[ELEM_W-1:0];
          r.adc_sum = (sa > 64'h3FFFFF) ? '1 : sa[SUM_W-1:0];
          r.cluster_tdc = tdc_mem[rep];
          r.hit_count = (cnt > 127) ? '1 : cnt[CNT_W-1:0];
          r.rep_index = rep[REP_W-1:0];
          r.none_found = 0;
          r.overflow = dropped;
          r.cluster_last = (c + 1 == emit);
          clusters_due.push_back(r);
        end
      end
      fill = 0;
      dropped = 0;
    endfunction

    function void field_cmp(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
        $display("%0t mismatch %s: expected %0d actual %0d", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    // called for every accepted cluster word
    function void check_cluster(cluster_t got);
      cluster_t want;
      if (clusters_due.size() == 0) begin
        $display("%0t unexpected cluster word: expected none, actual centroid %0d sum %0d",
                 $time, got.centroid, got.adc_sum);
        errors++;
        return;
      end
      want = clusters_due.pop_front();
      checked++;
      field_cmp("centroid", want.centroid, got.centroid);
      field_cmp("adc_sum", want.adc_sum, got.adc_sum);
      field_cmp("cluster_tdc", want.cluster_tdc, got.cluster_tdc);
      field_cmp("hit_count", want.hit_count, got.hit_count);
      field_cmp("rep_index", want.rep_index, got.rep_index);
      field_cmp("none_found", want.none_found, got.none_found);
      field_cmp("overflow", want.overflow, got.overflow);
      field_cmp("cluster_last", want.cluster_last, got.cluster_last);
    endfunction
  endclass

  logic                 clk = 0;
  logic                 rst = 1;
  logic                 cfg_valid = 0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;
  logic                 in_valid = 0;
  logic                 in_ready;
  logic [ELEM_W-1:0]    element = '0;
  logic [ADC_W-1:0]     adc = '0;
  logic [TDC_W-1:0]     tdc = '0;
  logic                 usable = 0;
  logic                 event_end = 0;
  logic                 out_valid;
  logic                 out_ready = 0;
  logic [ELEM_W-1:0]    centroid;
  logic [SUM_W-1:0]     adc_sum;
  logic [TDC_W-1:0]     cluster_tdc;
  logic [CNT_W-1:0]     hit_count;
  logic [REP_W-1:0]     rep_index;
  logic                 none_found;
  logic                 overflow;
  logic                 cluster_last;

  centroid_scoreboard sb = new();

  // knobs shared by the driving processes
  bit no_idle = 0;       // long stretch with no gaps on either side
  bit hold_req = 0;      // asks the receiver to hold off out_ready
  bit hold_done = 0;     // the hold-off runs only once
  int hold_left = 0;
  int quiet_cycles = 0;  // watchdog: cycles with no word moving
  int hits_sent = 0;

  localparam int WATCHDOG_LIMIT = 60000;

  always #5 clk = ~clk;

  hit_cluster_centroid_finder u_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .element(element), .adc(adc), .tdc(tdc), .usable(usable), .event_end(event_end),
    .out_valid(out_valid), .out_ready(out_ready),
    .centroid(centroid), .adc_sum(adc_sum), .cluster_tdc(cluster_tdc),
    .hit_count(hit_count), .rep_index(rep_index), .none_found(none_found),
    .overflow(overflow), .cluster_last(cluster_last)
  );

  // input monitor: every accepted hit word goes into the predictor
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      sb.note_hit(element, adc, tdc, usable, event_end);
      hits_sent++;
    end
  end

  // receiver: random back-pressure, a long hold-off on request,
  // and the check of every accepted cluster word
  always @(posedge clk) begin
    cluster_t got;
    if (rst) begin
      out_ready <= 0;
    end else begin
      if (out_valid && out_ready) begin
        got.centroid = centroid;
        got.adc_sum = adc_sum;
        got.cluster_tdc = cluster_tdc;
        got.hit_count = hit_count;
        got.rep_index = rep_index;
        got.none_found = none_found;
        got.overflow = overflow;
        got.cluster_last = cluster_last;
        sb.check_cluster(got);
      end
      if (hold_req && !hold_done) begin
        hold_left = 400;
        hold_done = 1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 0;
      end else begin
        out_ready <= no_idle || ($urandom_range(99) >= 25);
      end
    end
  end

  // watchdog on cycles with nothing moving on any channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t watchdog: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("** hit_cluster_centroid_finder: FAILED **");
        $finish;
      end
    end
  end

  // offer one hit word, sometimes after a random gap, and wait for acceptance
  task automatic send_hit(input logic [ELEM_W-1:0] e, input logic [ADC_W-1:0] a,
                          input logic [TDC_W-1:0] t, input logic u, input logic last);
    if (!no_idle && $urandom_range(99) < 25) begin
      in_valid <= 0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid <= 1;
    element <= e;
    adc <= a;
    tdc <= t;
    usable <= u;
    event_end <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // random adc, with zero and full scale now and then
  function automatic logic [ADC_W-1:0] pick_adc();
    int k;
    k = $urandom_range(9);
    if (k == 0) return '0;
    if (k == 1) return '1;
    if (k < 5) return ADC_W'($urandom_range(15));
    return ADC_W'($urandom);
  endfunction

  // one event of n words around a base element; most words usable
  task automatic send_event(input int n, input int spread);
    int base, e, k;
    k = $urandom_range(2);
    if (k == 0) base = 0;
    else if (k == 1) base = (sb.ecount > spread + 1) ? sb.ecount - spread - 1 : 0;
    else base = $urandom_range(255);
    for (int i = 0; i < n; i++) begin
      // near the low end some words jump to the wrap partner region
      e = ($urandom_range(3) == 0) ? (base + 255 - $urandom_range(spread)) % 256
                                   : (base + $urandom_range(spread)) % 256;
      send_hit(e[ELEM_W-1:0], pick_adc(), TDC_W'($urandom),
               $urandom_range(9) != 0, i == n - 1);
    end
  endtask

  // wait until every cluster word is back and the engine has settled,
  // then write a register
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    in_valid <= 0;
    @(posedge clk);
    while (sb.clusters_due.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    if (idx == CFG_WRAP_ENABLE) sb.wrap_on = val[0];
    else if (idx == CFG_ELEMENT_COUNT) sb.ecount = val;
  endtask

  logic [CFG_DAT_W-1:0] counts [7] = '{256, 256, 1, 0, 511, 200, 3};
  bit                   wraps  [7] = '{0, 1, 1, 1, 1, 1, 0};

  initial begin
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: empty events, extremes, zero weight, several clusters
    send_hit(8'd7, 16'd5, 16'd1, 1'b0, 1'b1);               // only unusable word
    send_hit(8'd0, 16'h0000, 16'hFFFF, 1'b1, 1'b1);         // zero adc sum
    send_hit(8'd255, 16'hFFFF, 16'h0000, 1'b1, 1'b1);       // full scale
    send_hit(8'd50, 16'd3, 16'd11, 1'b1, 1'b0);             // clusters out of order
    send_hit(8'd80, 16'd9, 16'd12, 1'b1, 1'b0);
    send_hit(8'd51, 16'd1, 16'd13, 1'b1, 1'b0);
    send_hit(8'd90, 16'd4, 16'd99, 1'b0, 1'b0);             // ignored mid-event
    send_hit(8'd50, 16'd2, 16'd14, 1'b1, 1'b0);             // second hit on centroid
    send_hit(8'd81, 16'd9, 16'd15, 1'b1, 1'b1);
    send_hit(8'd10, 16'd0, 16'd20, 1'b1, 1'b0);             // zero sum, two hits
    send_hit(8'd11, 16'd0, 16'd21, 1'b1, 1'b1);
    send_hit(8'd0, 16'd100, 16'd30, 1'b1, 1'b0);            // edges, no wrap yet
    send_hit(8'd255, 16'd100, 16'd31, 1'b1, 1'b1);

    // long hold-off on the output while short events keep coming
    hold_req = 1;
    no_idle = 1;
    for (int i = 0; i < 8; i++) send_event(3, 2);
    hold_req = 0;
    // store overflow, then a no-gap stretch of ordinary events
    send_event(80, 5);
    for (int i = 0; i < 10; i++) send_event($urandom_range(8, 1), 4);
    no_idle = 0;

    // config sweep; wrap directed pair first in each setting
    for (int p = 0; p < 7; p++) begin
      write_reg(CFG_WRAP_ENABLE, CFG_DAT_W'(wraps[p]));
      write_reg(CFG_ELEMENT_COUNT, counts[p]);
      send_hit(8'd0, 16'd40, 16'd70, 1'b1, 1'b0);
      send_hit(8'd255, 16'd40, 16'd71, 1'b1, 1'b1);
      for (int i = 0; i < 4; i++) send_event($urandom_range(10, 1), $urandom_range(6));
    end

    // writes to unused indexes are ignored
    write_reg(CFG_IDX_W'(2), '1);
    write_reg(CFG_IDX_W'(3), '0);
    send_event(66, 3);
    write_reg(CFG_ELEMENT_COUNT, ECNT_RESET);
    write_reg(CFG_WRAP_ENABLE, '0);
    for (int i = 0; i < 8; i++) send_event($urandom_range(6, 1), 3);
    in_valid <= 0;

    // drain and let the engine settle
    while (sb.clusters_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("ran %0d hit words in %0d events over 7 config settings", hits_sent, sb.events);
    $display("checked %0d cluster words, %0d mismatches", sb.checked, sb.errors);
    if (sb.errors == 0 && sb.clusters_due.size() == 0) begin
      $display("** hit_cluster_centroid_finder: PASSED **");
    end else begin
      $display("** hit_cluster_centroid_finder: FAILED **");
    end
    $finish;
  end

endmodule
